FILE: sv/s2da_pkg.sv
`default_nettype none

package s2da_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned BitCntW    = $clog2(ValueWidth);
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned LenWidth   = 4;

  localparam logic [CharWidth-1:0] CharZero  = 6'd48;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/s2da_bcd_cell.sv
`default_nettype none

module s2da_bcd_cell (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire s2da_pkg::cell_ctrl_t ctrl_i,
  input  wire                       bit_i,
  output logic                      carry_o,
  output s2da_pkg::bcd_t            digit_o
);

  s2da_pkg::bcd_t digit_q, digit_d;
  s2da_pkg::bcd_t adj;

  // add-3 correction before the shift
  always_comb begin
    adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    carry_o = adj[3];
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii.sv
`default_nettype none

// Signed 32-bit integer to decimal ASCII text, most significant character first.
// Input: value_i is taken at a rising edge where start is high and busy is low.
// busy stays high from the next cycle until the final character has been shown.
// Output: one beat per character, valid_o high for exactly one cycle per beat,
// carrying character_o, text_length_o (same on every beat of a value) and last_o.
// Negative values lead with a minus sign; zero gives a single '0'.
// Conversion runs through a row of ten BCD cells, shifting one magnitude bit per
// cycle, then sizes the text in the StSize state, then emits one beat per cycle.
// The next value can be started the cycle after last_o; none is taken while busy.
// The receiver cannot stall; beats are never held back.
// Reset (rst_ni low, asynchronous) returns the block to idle and drops any item
// in flight; no beat is produced for it.
module signed_int_to_decimal_ascii (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  wire signed [s2da_pkg::ValueWidth-1:0] value_i,
  output logic                               valid_o,
  output logic [s2da_pkg::CharWidth-1:0]     character_o,
  output logic [s2da_pkg::LenWidth-1:0]      text_length_o,
  output logic                               last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSize,
    StEmit
  } state_e;

  state_e state_q;
  logic [s2da_pkg::ValueWidth-1:0] mag_q;
  logic                            neg_q;
  logic                            minus_q;
  logic [s2da_pkg::BitCntW-1:0]    cnt_q;
  logic [s2da_pkg::DigitIdxW-1:0]  pos_q;
  logic [s2da_pkg::LenWidth-1:0]   len_q;

  logic                  accept;
  s2da_pkg::cell_ctrl_t  ctrl;
  logic [s2da_pkg::NumDigits:0] chain;
  s2da_pkg::bcd_t        digits [s2da_pkg::NumDigits];
  logic [s2da_pkg::DigitIdxW-1:0] lead;
  s2da_pkg::bcd_t        cur_digit;

  assign accept     = start && !busy;
  assign ctrl.clear = accept;
  assign ctrl.shift = (state_q == StConv);
  assign chain[0]   = mag_q[s2da_pkg::ValueWidth-1];

  for (genvar g = 0; g < s2da_pkg::NumDigits; g++) begin : g_cell
    s2da_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (chain[g]),
      .carry_o (chain[g+1]),
      .digit_o (digits[g])
    );
  end

  // highest nonzero digit, zero if all digits are zero
  always_comb begin
    lead = '0;
    for (int i = 1; i < s2da_pkg::NumDigits; i++) begin
      if (digits[i] != 4'd0) begin
        lead = s2da_pkg::DigitIdxW'(i);
      end
    end
  end

  assign cur_digit = digits[pos_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      minus_q <= 1'b0;
      cnt_q   <= '0;
      pos_q   <= '0;
      len_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start) begin
            neg_q   <= value_i[s2da_pkg::ValueWidth-1];
            mag_q   <= value_i[s2da_pkg::ValueWidth-1] ?
                       (s2da_pkg::ValueWidth)'(32'd0 - value_i) : value_i;
            cnt_q   <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          mag_q <= {mag_q[s2da_pkg::ValueWidth-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == {s2da_pkg::BitCntW{1'b1}}) begin
            state_q <= StSize;
          end
        end
        StSize: begin
          pos_q   <= lead;
          minus_q <= neg_q;
          len_q   <= s2da_pkg::LenWidth'(lead) + 4'd1 + {3'd0, neg_q};
          state_q <= StEmit;
        end
        StEmit: begin
          if (minus_q) begin
            minus_q <= 1'b0;
          end else if (pos_q == '0) begin
            state_q <= StIdle;
          end else begin
            pos_q <= pos_q - 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy          = (state_q != StIdle);
  assign valid_o       = (state_q == StEmit);
  assign character_o   = minus_q ? s2da_pkg::CharMinus
                                 : s2da_pkg::CharZero + {2'b00, cur_digit};
  assign text_length_o = len_q;
  assign last_o        = valid_o && !minus_q && (pos_q == '0);

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("beat shown while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy)
    else $error("still busy after last beat");

  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (valid_o && $stable(text_length_o)))
    else $error("text broken or length changed mid-text");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !valid_o))
    else $error("accepted item not taken up");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [s2da_pkg::CharWidth-1:0] ch;
    logic [s2da_pkg::LenWidth-1:0]  len;
    logic                           last;
  } text_beat_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic [s2da_pkg::ValueWidth-1:0] value_i;
  logic                            valid_o;
  logic [s2da_pkg::CharWidth-1:0]  character_o;
  logic [s2da_pkg::LenWidth-1:0]   text_length_o;
  logic                            last_o;

  logic [s2da_pkg::ValueWidth-1:0] value_q[$];
  text_beat_t            text_q[$];
  int unsigned           accept_cnt = 0;
  int unsigned           issue_cnt = 0;
  int unsigned           idle_pct = 0;
  int unsigned           errors = 0;

  signed_int_to_decimal_ascii uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .character_o   (character_o),
    .text_length_o (text_length_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1ms;
    $display("FAIL signed_int_to_decimal_ascii");
    $finish;
  end

  // decimal text of one value, most significant character first
  task automatic predict_text(input logic [s2da_pkg::ValueWidth-1:0] raw);
    logic                 neg;
    logic [31:0]          mag;
    logic [3:0]           digs[s2da_pkg::NumDigits];
    int                   ndig;
    int                   len;
    int                   pos;
    text_beat_t           b;
    neg = raw[s2da_pkg::ValueWidth-1];
    mag = neg ? (32'd0 - raw) : raw;
    ndig = 0;
    if (mag == 0) begin
      digs[0] = 4'd0;
      ndig = 1;
    end else begin
      while (mag != 0 && ndig < s2da_pkg::NumDigits) begin
        digs[ndig] = 4'(mag % 10);
        mag = mag / 10;
        ndig++;
      end
    end
    len = ndig + (neg ? 1 : 0);
    pos = 0;
    b.len = s2da_pkg::LenWidth'(len);
    if (neg) begin
      b.ch = s2da_pkg::CharMinus;
      b.last = (pos == len - 1);
      text_q.push_back(b);
      pos++;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      b.ch = s2da_pkg::CharZero + s2da_pkg::CharWidth'(digs[k]);
      b.last = (pos == len - 1);
      text_q.push_back(b);
      pos++;
    end
  endtask

  function automatic logic [s2da_pkg::ValueWidth-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    bit     neg;
    int     n;
    neg = $urandom_range(1);
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        n = $urandom_range(1, s2da_pkg::NumDigits);
        lo = 1;
        for (int k = 1; k < n; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (n == 1) lo = 0;
        if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = lo + ($urandom % (hi - lo + 1));
        return neg ? s2da_pkg::ValueWidth'(-mag) : s2da_pkg::ValueWidth'(mag);
      end
      2: return s2da_pkg::ValueWidth'($urandom_range(40) - 20);
      default: begin
        n = $urandom_range(0, 9);
        mag = 1;
        for (int k = 0; k < n; k++) mag = mag * 10;
        mag = mag + $urandom_range(2) - 1;
        return neg ? s2da_pkg::ValueWidth'(-mag) : s2da_pkg::ValueWidth'(mag);
      end
    endcase
  endfunction

  // driver: one item on the ports until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || accept_cnt == issue_cnt) begin
        if (value_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start   <= 1'b1;
          value_i <= value_q.pop_front();
          issue_cnt <= issue_cnt + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: input acceptance and character beats
  always @(posedge clk_i) begin
    text_beat_t e;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_text(value_i);
        accept_cnt <= accept_cnt + 1;
      end
      if (valid_o) begin
        if (text_q.size() == 0) begin
          $error("unexpected beat: character %0d", character_o);
          errors++;
        end else begin
          e = text_q.pop_front();
          if (character_o !== e.ch) begin
            $error("character: expected %0d, actual %0d", e.ch, character_o);
            errors++;
          end
          if (text_length_o !== e.len) begin
            $error("text_length: expected %0d, actual %0d", e.len, text_length_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [s2da_pkg::ValueWidth-1:0] directed[$];
    int unsigned           pcts[3];
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd999999999,
                 32'd1000000000, -32'sd1000000000, 32'h5555_5555, 32'haaaa_aaaa,
                 32'd123456789, -32'sd123456789, 32'd1000000001, -32'sd999999999};
    pcts = '{0, 82, 10};
    start   = 1'b0;
    value_i = '0;
    rst_ni  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < 3; p++) begin
      idle_pct = pcts[p];
      if (p == 0) begin
        foreach (directed[i]) value_q.push_back(directed[i]);
      end
      repeat (50) value_q.push_back(random_value());
      wait (value_q.size() == 0 && !start && text_q.size() == 0);
      @(posedge clk_i);
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && text_q.size() == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/s2da_pkg.sv
sv/s2da_bcd_cell.sv
sv/signed_int_to_decimal_ascii.sv
test/testbench.sv
